@@ rtl/plti_pkg.sv @@
// Package with shared types and codes for the piecewise-linear table interpolator.
`default_nettype none

package plti_pkg;

    // Command codes of an input word.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes of a result word.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_FEW   = 3'd2;
    localparam logic [2:0] ST_EQX   = 3'd3;
    localparam logic [2:0] ST_SAT   = 3'd4;

    // Operation strobes broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic qry;
    } t_cell_ctl;

    // Handshake and flags from the arithmetic unit.
    typedef struct packed {
        logic done;
        logic ovf;
    } t_arith_st;

endpackage

`default_nettype wire

@@ rtl/piecewise_linear_table_interpolator.sv @@
// Top level of the piecewise-linear table interpolator: chain of point cells and query control.
//
// Channel | Direction | Handshake          | Word
// in      | input     | i_valid / o_stall  | i_command, i_x_value, i_y_value
// out     | output    | o_valid / i_stall  | o_result_y, o_status, o_point_count
//
// Clear and insert pass S_EXEC and S_DONE only; insert moves all cells above its place up together.
// A query passes the segment select, the partial-product multiply and the 33-step restoring
// divider; a query that fails early, with too few points or equal x, skips the arithmetic.
// One word is worked on at a time; a new word is taken while a result waits in the output register.
// Synchronous active-low reset empties the table; point storage needs no clearing.
`default_nettype none

module piecewise_linear_table_interpolator
    import plti_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_command,
    input  wire logic signed [31:0] i_x_value,
    input  wire logic signed [31:0] i_y_value,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_result_y,
    output logic [2:0]              o_status,
    output logic [CW-1:0]           o_point_count
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_ARTH = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]         r_state;
    logic [1:0]         r_cmd;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [CW-1:0]      r_cnt;
    logic signed [31:0] r_xa;
    logic signed [31:0] r_ya;
    logic signed [31:0] r_xb;
    logic signed [31:0] r_yb;
    logic [33:0]        r_dqm;
    logic [33:0]        r_dym;
    logic [32:0]        r_dx;
    logic               r_neg;
    logic               r_start;
    logic signed [31:0] r_res;
    logic [2:0]         r_st;
    logic               r_ovalid;
    logic signed [31:0] r_ores;
    logic [2:0]         r_ost;
    logic [CW-1:0]      r_ocnt;

    t_cell_ctl          ctl;
    t_arith_st          ast;
    logic [32:0]        quo;
    logic signed [31:0] w_x [TABLE_DEPTH];
    logic signed [31:0] w_y [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_gt;
    logic [TABLE_DEPTH-1:0] w_le;
    logic [TABLE_DEPTH-1:0] w_sel;
    logic signed [31:0] g_xa;
    logic signed [31:0] g_ya;
    logic signed [31:0] g_xb;
    logic signed [31:0] g_yb;
    logic signed [32:0] dq;
    logic signed [32:0] dy;
    logic signed [32:0] dx;
    logic signed [34:0] sq;
    logic signed [34:0] ysum;

    // Operation strobes for the chain.
    assign ctl.ins = (r_state == S_EXEC) && (r_cmd == CMD_INSERT)
                     && (r_cnt < CW'(TABLE_DEPTH));
    assign ctl.qry = (r_state == S_EXEC) && (r_cmd == CMD_QUERY);

    // Row of point cells, each fed by its left neighbor.
    for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
        plti_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_count   (r_cnt),
            .i_arg_x   (r_x),
            .i_arg_y   (r_y),
            .i_prev_x  ((gi == 0) ? r_x : w_x[(gi == 0) ? 0 : gi - 1]),
            .i_prev_y  ((gi == 0) ? r_y : w_y[(gi == 0) ? 0 : gi - 1]),
            .i_prev_gt ((gi == 0) ? 1'b0 : w_gt[(gi == 0) ? 0 : gi - 1]),
            .i_next_le ((gi == TABLE_DEPTH - 1) ? 1'b0
                        : w_le[(gi == TABLE_DEPTH - 1) ? gi : gi + 1]),
            .o_x       (w_x[gi]),
            .o_y       (w_y[gi]),
            .o_gt      (w_gt[gi]),
            .o_le      (w_le[gi]),
            .o_sel     (w_sel[gi])
        );
    end

    // Gather the two points of the flagged segment; exactly one cell is flagged.
    always_comb begin
        g_xa = '0;
        g_ya = '0;
        g_xb = '0;
        g_yb = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (w_sel[i]) begin
                g_xa = g_xa | w_x[i];
                g_ya = g_ya | w_y[i];
            end
            if (i > 0 && w_sel[(i > 0) ? i - 1 : 0]) begin
                g_xb = g_xb | w_x[i];
                g_yb = g_yb | w_y[i];
            end
        end
    end

    // Segment differences at 33 bits.
    assign dq = {r_x[31], r_x} - {r_xa[31], r_xa};
    assign dy = {r_yb[31], r_yb} - {r_ya[31], r_ya};
    assign dx = {r_xb[31], r_xb} - {r_xa[31], r_xa};

    plti_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (r_dqm),
        .i_b     (r_dym),
        .i_d     (r_dx),
        .o_st    (ast),
        .o_q     (quo)
    );

    // Signed step added to the segment start.
    assign sq   = r_neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    assign ysum = {{3{r_ya[31]}}, r_ya} + sq;

    // Sequencer for one word at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_command;
                        r_x     <= i_x_value;
                        r_y     <= i_y_value;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res   <= '0;
                    r_st    <= ST_OK;
                    r_state <= S_DONE;
                    case (r_cmd)
                        CMD_CLEAR: r_cnt <= '0;
                        CMD_INSERT: begin
                            if (r_cnt < CW'(TABLE_DEPTH)) begin
                                r_cnt <= r_cnt + CW'(1);
                            end else begin
                                r_st <= ST_FULL;
                            end
                        end
                        CMD_QUERY: begin
                            if (r_cnt < CW'(2)) begin
                                r_st <= ST_FEW;
                            end else begin
                                r_state <= S_SEL;
                            end
                        end
                        default: r_st <= ST_OK;
                    endcase
                end
                S_SEL: begin
                    r_xa    <= g_xa;
                    r_ya    <= g_ya;
                    r_xb    <= g_xb;
                    r_yb    <= g_yb;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (dx <= 33'sd0) begin
                        r_st    <= ST_EQX;
                        r_state <= S_DONE;
                    end else begin
                        r_dqm   <= {1'b0, dq[32] ? -dq : dq};
                        r_dym   <= {1'b0, dy[32] ? -dy : dy};
                        r_dx    <= dx;
                        r_neg   <= dq[32] != dy[32];
                        r_start <= 1'b1;
                        r_state <= S_ARTH;
                    end
                end
                S_ARTH: begin
                    if (ast.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                    if (ast.ovf || ysum > 35'sh7FFFFFFF || ysum < -35'sh80000000) begin
                        r_st  <= ST_SAT;
                        r_res <= (ast.ovf ? r_neg : ysum[34]) ? 32'sh80000000
                                                              : 32'sh7FFFFFFF;
                    end else begin
                        r_res <= ysum[31:0];
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register: loaded when a word finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            r_ovalid <= 1'b1;
            r_ores   <= r_res;
            r_ost    <= r_st;
            r_ocnt   <= r_cnt;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_stall       = r_state != S_IDLE;
    assign o_valid       = r_ovalid;
    assign o_result_y    = r_ores;
    assign o_status      = r_ost;
    assign o_point_count = r_ocnt;

endmodule

`default_nettype wire

@@ rtl/plti_cell.sv @@
// One breakpoint cell of the sorted chain: holds a point, shifts on insert, flags the segment.
`default_nettype none

module plti_cell
    import plti_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  wire logic               i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic signed [31:0] i_arg_x,
    input  wire logic signed [31:0] i_arg_y,
    input  wire logic signed [31:0] i_prev_x,
    input  wire logic signed [31:0] i_prev_y,
    input  wire logic               i_prev_gt,
    input  wire logic               i_next_le,
    output logic signed [31:0]      o_x,
    output logic signed [31:0]      o_y,
    output logic                    o_gt,
    output logic                    o_le,
    output logic                    o_sel
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic               r_sel;
    logic               live;
    logic               tail;
    logic               penult;
    logic               at_end;
    logic               above;

    // Position of this cell relative to the fill count.
    assign live   = CW'(IDX) < i_count;
    assign at_end = CW'(IDX) == i_count;
    assign tail   = CW'(IDX + 1) == i_count;
    assign penult = CW'(IDX + 2) == i_count;

    // One comparator serves both the insert place and the query search.
    assign above = r_x > i_arg_x;
    assign o_gt  = live && above;
    assign o_le  = live && !above;

    // Insert: move up when the left neighbor moves, take the new point at the gap.
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (i_prev_gt) begin
                r_x <= i_prev_x;
                r_y <= i_prev_y;
            end else if (o_gt || at_end) begin
                r_x <= i_arg_x;
                r_y <= i_arg_y;
            end
        end
    end

    // Query: this cell starts the segment when it is the last point not above the argument,
    // clamped to the first and the last segment.
    always_ff @(posedge i_clk) begin
        if (i_ctl.qry) begin
            r_sel <= live && !tail && ((IDX == 0) || o_le) && (penult || !i_next_le);
        end
    end

    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_sel = r_sel;

endmodule

`default_nettype wire

@@ rtl/plti_arith.sv @@
// Multiply-then-divide unit: floor(a * b / d) over 17-bit partial products and a restoring divider.
`default_nettype none

module plti_arith
    import plti_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [33:0] i_a,
    input  wire logic [33:0] i_b,
    input  wire logic [32:0] i_d,
    output t_arith_st        o_st,
    output logic [32:0]      o_q
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_CHK  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    logic [1:0]  r_state;
    logic [2:0]  r_k;
    logic [5:0]  r_cnt;
    logic [33:0] r_pp;
    logic [1:0]  r_sh;
    logic [67:0] r_acc;
    logic [32:0] r_rem;
    logic [32:0] r_quo;
    logic        r_done;
    logic        r_ovf;
    logic [16:0] pa;
    logic [16:0] pb;
    logic [67:0] pp_shift;
    logic [33:0] trial;
    logic [33:0] diff;

    // Partial product operands, one pair per cycle.
    always_comb begin
        case (r_k[1:0])
            2'd0: begin pa = i_a[16:0];  pb = i_b[16:0];  end
            2'd1: begin pa = i_a[33:17]; pb = i_b[16:0];  end
            2'd2: begin pa = i_a[16:0];  pb = i_b[33:17]; end
            default: begin pa = i_a[33:17]; pb = i_b[33:17]; end
        endcase
    end

    // Weight of the registered partial product.
    always_comb begin
        case (r_sh)
            2'd0:    pp_shift = {34'd0, r_pp};
            2'd1:    pp_shift = {17'd0, r_pp, 17'd0};
            default: pp_shift = {r_pp, 34'd0};
        endcase
    end

    // One restoring step: the next dividend bit comes from the top of r_quo.
    assign trial = {r_rem, r_quo[32]};
    assign diff  = trial - {1'b0, i_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_k     <= 3'd0;
                        r_acc   <= 68'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_k != 3'd4) begin
                        r_pp <= pa * pb;
                        case (r_k[1:0])
                            2'd0:    r_sh <= 2'd0;
                            2'd3:    r_sh <= 2'd2;
                            default: r_sh <= 2'd1;
                        endcase
                    end
                    if (r_k != 3'd0) begin
                        r_acc <= r_acc + pp_shift;
                    end
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'd4) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    // A quotient of 2^33 or more cannot fit the result at all.
                    if (r_acc[67:33] >= {2'b0, i_d}) begin
                        r_ovf   <= 1'b1;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_ovf   <= 1'b0;
                        r_rem   <= r_acc[65:33];
                        r_quo   <= r_acc[32:0];
                        r_cnt   <= 6'd33;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (trial >= {1'b0, i_d}) begin
                        r_rem <= diff[32:0];
                        r_quo <= {r_quo[31:0], 1'b1};
                    end else begin
                        r_rem <= trial[32:0];
                        r_quo <= {r_quo[31:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_st.done = r_done;
    assign o_st.ovf  = r_ovf;
    assign o_q       = r_quo;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the piecewise-linear table interpolator.
module tb;
    import plti_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_command;
    logic signed [31:0] i_x_value;
    logic signed [31:0] i_y_value;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result_y;
    logic [2:0]         o_status;
    logic [6:0]         o_point_count;

    localparam int DEPTH = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam logic signed [127:0] QUOT_CAP = 128'sd1 <<< 62;

    typedef struct {
        logic signed [31:0] y;
        logic [2:0]         st;
        logic [6:0]         cnt;
    } result_t;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 typed;
        result_t            res;
    } row_t;

    // Shadow copy of the breakpoint table.
    logic signed [31:0] shadow_x[DEPTH];
    logic signed [31:0] shadow_y[DEPTH];
    int                 shadow_held;

    result_t pending_results[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      words_sent;
    row_t    dir_rows[25];

    piecewise_linear_table_interpolator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command), .i_x_value(i_x_value), .i_y_value(i_y_value),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_y(o_result_y),
        .o_status(o_status), .o_point_count(o_point_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Apply one word to the shadow table and work out its result.
    function automatic result_t apply_word(input logic [1:0] cmd,
                                           input logic signed [31:0] x,
                                           input logic signed [31:0] y);
        result_t r;
        int pos;
        int seg;
        logic signed [127:0] dq, dy, dx, quot, ysum;
        r.y  = '0;
        r.st = ST_OK;
        if (cmd == CMD_CLEAR) begin
            shadow_held = 0;
        end else if (cmd == CMD_INSERT) begin
            if (shadow_held >= DEPTH) begin
                r.st = ST_FULL;
            end else begin
                pos = shadow_held;
                while (pos > 0 && shadow_x[pos-1] > x) begin
                    shadow_x[pos] = shadow_x[pos-1];
                    shadow_y[pos] = shadow_y[pos-1];
                    pos--;
                end
                shadow_x[pos] = x;
                shadow_y[pos] = y;
                shadow_held++;
            end
        end else if (cmd == CMD_QUERY) begin
            if (shadow_held < 2) begin
                r.st = ST_FEW;
            end else begin
                // Segment starts at the last point not above x, clamped to the ends.
                seg = 0;
                for (int i = 0; i < shadow_held; i++)
                    if (shadow_x[i] <= x) seg = i;
                if (seg > shadow_held - 2) seg = shadow_held - 2;
                dx = shadow_x[seg+1];
                dx = dx - shadow_x[seg];
                if (dx <= 0) begin
                    r.st = ST_EQX;
                end else begin
                    dq = x;
                    dq = dq - shadow_x[seg];
                    dy = shadow_y[seg+1];
                    dy = dy - shadow_y[seg];
                    quot = (dq * dy) / dx;
                    if (quot >= QUOT_CAP || quot <= -QUOT_CAP) begin
                        r.y  = (quot < 0) ? S32_MIN : S32_MAX;
                        r.st = ST_SAT;
                    end else begin
                        ysum = shadow_y[seg];
                        ysum = ysum + quot;
                        if (ysum > S32_MAX) begin
                            r.y  = S32_MAX;
                            r.st = ST_SAT;
                        end else if (ysum < S32_MIN) begin
                            r.y  = S32_MIN;
                            r.st = ST_SAT;
                        end else begin
                            r.y = ysum[31:0];
                        end
                    end
                end
            end
        end
        r.cnt = shadow_held[6:0];
        return r;
    endfunction

    // Drive one word, wait for it to be taken, and record its expected result.
    task automatic send_word(input logic [1:0] cmd, input logic signed [31:0] x,
                             input logic signed [31:0] y, input bit typed,
                             input result_t typed_res);
        result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_x_value <= x;
        i_y_value <= y;
        do @(posedge i_clk); while (o_stall);
        r = apply_word(cmd, x, y);
        pending_results.push_back(typed ? typed_res : r);
        words_sent++;
    endtask

    task automatic send_rand(input logic [1:0] cmd, input logic signed [31:0] x,
                             input logic signed [31:0] y);
        result_t none;
        none = '{default: '0};
        send_word(cmd, x, y, 1'b0, none);
    endtask

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return ($urandom_range(1)) ? S32_MAX : S32_MIN;
            2, 3:    return $signed($urandom_range(40)) - 20;
            default: return ($signed($urandom_range(200)) - 100) <<< 16;
        endcase
    endfunction

    // A clear, a run of inserts, then queries mostly near the breakpoints.
    task automatic run_sequence();
        int n_points;
        int n_queries;
        logic signed [31:0] qx;
        send_rand(CMD_CLEAR, $urandom, $urandom);
        case ($urandom_range(19))
            0:       n_points = DEPTH + 2;
            1:       n_points = $urandom_range(1);
            default: n_points = $urandom_range(2, 8);
        endcase
        for (int i = 0; i < n_points; i++)
            send_rand(CMD_INSERT, pick_coord(), pick_coord());
        n_queries = $urandom_range(3, 10);
        for (int i = 0; i < n_queries; i++) begin
            case ($urandom_range(9))
                0: begin
                    send_rand(CMD_UNUSED, $urandom, $urandom);
                    qx = pick_coord();
                end
                1: begin
                    send_rand(CMD_INSERT, pick_coord(), pick_coord());
                    qx = pick_coord();
                end
                2:       qx = $urandom;
                default: begin
                    qx = (shadow_held > 0) ? shadow_x[$urandom_range(shadow_held - 1)]
                                           : pick_coord();
                    qx = qx + $signed($urandom_range(1 << 18)) - (1 << 17);
                end
            endcase
            send_rand(CMD_QUERY, qx, $urandom);
        end
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Compare each result word with the oldest expectation.
    always @(posedge i_clk) begin
        result_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: result_y=%0d status=%0d",
                       o_result_y, o_status);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_y !== e.y) begin
                    $error("result_y: expected %0d, got %0d", e.y, o_result_y);
                    fail_count++;
                end
                if (o_status !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, o_status);
                    fail_count++;
                end
                if (o_point_count !== e.cnt) begin
                    $error("point_count: expected %0d, got %0d", e.cnt, o_point_count);
                    fail_count++;
                end
            end
        end
    end

    function automatic row_t mk(input logic [1:0] cmd, input logic signed [31:0] x,
                                input logic signed [31:0] y, input bit typed,
                                input logic signed [31:0] ey, input logic [2:0] est,
                                input logic [6:0] ecnt);
        row_t r;
        r.cmd = cmd; r.x = x; r.y = y; r.typed = typed;
        r.res.y = ey; r.res.st = est; r.res.cnt = ecnt;
        return r;
    endfunction

    initial begin
        i_rst_n = 1'b0; i_valid = 1'b0; i_command = CMD_CLEAR;
        i_x_value = '0; i_y_value = '0; i_stall = 1'b0;
        fail_count = 0; words_sent = 0; shadow_held = 0;
        send_idle_pct = 6; recv_idle_pct = 83;

        // Directed rows: empty and one-point queries, extremes, equal x, saturation.
        dir_rows[0]  = mk(CMD_QUERY,  0, 0, 1, 0, ST_FEW, 0);
        dir_rows[1]  = mk(CMD_INSERT, 0, 0, 1, 0, ST_OK, 1);
        dir_rows[2]  = mk(CMD_QUERY,  0, 5, 1, 0, ST_FEW, 1);
        dir_rows[3]  = mk(CMD_INSERT, 32'sh10000, 32'sh10000, 1, 0, ST_OK, 2);
        dir_rows[4]  = mk(CMD_QUERY,  32'sh8000, 0, 0, 0, ST_OK, 0);
        dir_rows[5]  = mk(CMD_QUERY,  S32_MIN, 0, 0, 0, ST_OK, 0);
        dir_rows[6]  = mk(CMD_QUERY,  S32_MAX, 0, 0, 0, ST_OK, 0);
        dir_rows[7]  = mk(CMD_UNUSED, S32_MAX, S32_MIN, 1, 0, ST_OK, 2);
        dir_rows[8]  = mk(CMD_CLEAR,  -1, -1, 1, 0, ST_OK, 0);
        dir_rows[9]  = mk(CMD_INSERT, 32'sh50000, 7, 1, 0, ST_OK, 1);
        dir_rows[10] = mk(CMD_INSERT, 32'sh50000, 9, 1, 0, ST_OK, 2);
        dir_rows[11] = mk(CMD_QUERY,  0, 0, 1, 0, ST_EQX, 2);
        dir_rows[12] = mk(CMD_QUERY,  32'sha0000, 0, 1, 0, ST_EQX, 2);
        dir_rows[13] = mk(CMD_CLEAR,  0, 0, 1, 0, ST_OK, 0);
        dir_rows[14] = mk(CMD_INSERT, S32_MAX, S32_MAX, 1, 0, ST_OK, 1);
        dir_rows[15] = mk(CMD_INSERT, S32_MIN, S32_MIN, 1, 0, ST_OK, 2);
        dir_rows[16] = mk(CMD_QUERY,  0, 0, 0, 0, ST_OK, 0);
        dir_rows[17] = mk(CMD_QUERY,  S32_MIN, 0, 0, 0, ST_OK, 0);
        dir_rows[18] = mk(CMD_CLEAR,  0, 0, 1, 0, ST_OK, 0);
        dir_rows[19] = mk(CMD_INSERT, 0, S32_MIN, 1, 0, ST_OK, 1);
        dir_rows[20] = mk(CMD_INSERT, 1, S32_MAX, 1, 0, ST_OK, 2);
        dir_rows[21] = mk(CMD_QUERY,  S32_MAX, 0, 1, S32_MAX, ST_SAT, 2);
        dir_rows[22] = mk(CMD_QUERY,  S32_MIN, 0, 1, S32_MIN, ST_SAT, 2);
        dir_rows[23] = mk(CMD_INSERT, -1, 0, 1, 0, ST_OK, 3);
        dir_rows[24] = mk(CMD_QUERY,  -32'sh8000, 0, 0, 0, ST_OK, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            send_word(dir_rows[i].cmd, dir_rows[i].x, dir_rows[i].y,
                      dir_rows[i].typed, dir_rows[i].res);

        // Random sequences over three idling phases.
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 83 : 0;
            recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 6 : 0;
            while (words_sent < 25 + 170 * (phase + 1))
                run_sequence();
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("** piecewise_linear_table_interpolator: PASSED **");
        else
            $display("** piecewise_linear_table_interpolator: FAILED **");
        $finish;
    end

    // Run limit.
    initial begin
        #8000000;
        $display("** piecewise_linear_table_interpolator: FAILED **");
        $finish;
    end

endmodule
